// ===== src/alarm_list_and_daily_timer_macros.svh =====
// Assertion helpers used by the alarm unit controller (alm_ctrl).
`ifndef ALARM_LIST_AND_DAILY_TIMER_MACROS_SVH
`define ALARM_LIST_AND_DAILY_TIMER_MACROS_SVH

// Same-cycle implication.
`define ALM_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ALM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/alm_pkg.sv =====
package alm_pkg;

   localparam int MINUTE_W    = 11;
   localparam int DAY_W       = 9;
   localparam int CODE_W      = 8;
   localparam int REPLY_W     = 16;
   localparam int SLOT_IDX_W  = 8;
   localparam int ACTION_W    = 2;
   localparam int KIND_W      = 3;
   localparam int SLOT_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam int ALARM_SLOTS_DEFAULT = 8;
   localparam int MAX_FIRES           = 8;
   localparam int FIRE_CNT_W          = 4;
   localparam logic [FIRE_CNT_W-1:0] FIRE_CNT_LAST = FIRE_CNT_W'(MAX_FIRES - 1);

   typedef enum logic [ACTION_W-1:0] {
      ACTION_TICK   = 2'd0,
      ACTION_ADD    = 2'd1,
      ACTION_REMOVE = 2'd2
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE     = 3'd0,
      KIND_ONE_SHOT = 3'd1,
      KIND_OPEN     = 3'd2,
      KIND_CLOSE    = 3'd3,
      KIND_ADDED    = 3'd4,
      KIND_FULL     = 3'd5,
      KIND_REMOVED  = 3'd6,
      KIND_IGNORED  = 3'd7
   } kind_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_DAILY_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_EACH_DAY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_MINUTE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_PRESENT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_MINUTE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_PRESENT   = 3'd5;

   typedef struct packed {
      logic [MINUTE_W-1:0] minute;
      logic [CODE_W-1:0]   action;
      logic [REPLY_W-1:0]  reply;
   } entry_type;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   slot;
      logic [CODE_W-1:0]   fired_action;
      logic [REPLY_W-1:0]  fired_reply;
   } result_type;

   // daily alarm outcome of the item offered on the request channel
   typedef struct packed {
      logic fire_open;
      logic fire_close;
      logic active;
   } daily_type;

   typedef struct packed {
      logic eval;
      logic commit;
   } daily_ctrl_type;

endpackage

// ===== src/alm_req_if.sv =====
interface alm_req_if;
   logic                             valid;
   logic                             ready;
   logic [alm_pkg::ACTION_W-1:0]     action;
   logic                             clock_synced;
   logic [alm_pkg::MINUTE_W-1:0]     now_minute;
   logic [alm_pkg::DAY_W-1:0]        day_of_year;
   logic [alm_pkg::MINUTE_W-1:0]     alarm_minute;
   logic [alm_pkg::CODE_W-1:0]       alarm_action;
   logic [alm_pkg::REPLY_W-1:0]      alarm_reply;
   logic [alm_pkg::SLOT_IDX_W-1:0]   slot_index;

   modport source (
      output valid, action, clock_synced, now_minute, day_of_year,
             alarm_minute, alarm_action, alarm_reply, slot_index,
      input  ready
   );
   modport sink (
      input  valid, action, clock_synced, now_minute, day_of_year,
             alarm_minute, alarm_action, alarm_reply, slot_index,
      output ready
   );
endinterface

// ===== src/alm_rsp_if.sv =====
interface alm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [alm_pkg::KIND_W-1:0]    kind;
   logic [alm_pkg::SLOT_W-1:0]    slot;
   logic [alm_pkg::CODE_W-1:0]    fired_action;
   logic [alm_pkg::REPLY_W-1:0]   fired_reply;
   logic                          daily_active;
   logic                          last;

   modport source (
      output valid, kind, slot, fired_action, fired_reply, daily_active, last,
      input  ready
   );
   modport sink (
      input  valid, kind, slot, fired_action, fired_reply, daily_active, last,
      output ready
   );
endinterface

// ===== src/alm_store.sv =====
module alm_store #(
   parameter int ALARM_SLOTS = alm_pkg::ALARM_SLOTS_DEFAULT,
   localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output alm_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  alm_pkg::entry_type  wr_data
);

   alm_pkg::entry_type mem_ff [ALARM_SLOTS];
   alm_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/alm_daily.sv =====
module alm_daily (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [alm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [alm_pkg::CSR_DATA_W-1:0]       csr_data,
   input  alm_pkg::daily_ctrl_type              ctrl,
   input  logic [alm_pkg::MINUTE_W-1:0]         now_minute,
   input  logic [alm_pkg::DAY_W-1:0]            day_of_year,
   output alm_pkg::daily_type                   status
);

   logic                          enable_ff, enable_in;
   logic                          repeat_ff, repeat_in;
   logic [alm_pkg::MINUTE_W-1:0]  open_min_ff, open_min_in;
   logic                          open_pres_ff, open_pres_in;
   logic [alm_pkg::MINUTE_W-1:0]  close_min_ff, close_min_in;
   logic                          close_pres_ff, close_pres_in;
   logic                          open_valid_ff, open_valid_in;
   logic [alm_pkg::DAY_W-1:0]     open_day_ff, open_day_in;
   logic                          close_valid_ff, close_valid_in;
   logic [alm_pkg::DAY_W-1:0]     close_day_ff, close_day_in;
   logic                          completed_ff, completed_in;

   logic armed, open_today, close_today, fire_open, fire_close;
   logic open_settled, close_settled, complete_now;

   always_comb begin
      open_today  = open_valid_ff && (open_day_ff == day_of_year);
      close_today = close_valid_ff && (close_day_ff == day_of_year);
      armed       = enable_ff && !completed_ff && (open_pres_ff || close_pres_ff);
      fire_open   = ctrl.eval && armed && open_pres_ff && (open_min_ff == now_minute)
                    && !open_today;
      fire_close  = ctrl.eval && armed && close_pres_ff && (close_min_ff == now_minute)
                    && !close_today;
      open_settled  = !open_pres_ff || fire_open || open_today;
      close_settled = !close_pres_ff || fire_close || close_today;
      complete_now  = ctrl.eval && armed && !repeat_ff && open_settled && close_settled;

      status.fire_open  = fire_open;
      status.fire_close = fire_close;
      status.active     = enable_ff && !(completed_ff || complete_now);

      enable_in      = enable_ff;
      repeat_in      = repeat_ff;
      open_min_in    = open_min_ff;
      open_pres_in   = open_pres_ff;
      close_min_in   = close_min_ff;
      close_pres_in  = close_pres_ff;
      open_valid_in  = open_valid_ff;
      open_day_in    = open_day_ff;
      close_valid_in = close_valid_ff;
      close_day_in   = close_day_ff;
      completed_in   = completed_ff;

      if (ctrl.commit) begin
         if (fire_open) begin
            open_valid_in = 1'b1;
            open_day_in   = day_of_year;
         end
         if (fire_close) begin
            close_valid_in = 1'b1;
            close_day_in   = day_of_year;
         end
         if (complete_now) begin
            completed_in = 1'b1;
         end
      end

      if (csr_write_en) begin
         // any listed register clears the day marks; others are dropped
         unique case (csr_index)
            alm_pkg::CSR_DAILY_ENABLE:    enable_in     = csr_data[0];
            alm_pkg::CSR_REPEAT_EACH_DAY: repeat_in     = csr_data[0];
            alm_pkg::CSR_OPEN_MINUTE:     open_min_in   = csr_data;
            alm_pkg::CSR_OPEN_PRESENT:    open_pres_in  = csr_data[0];
            alm_pkg::CSR_CLOSE_MINUTE:    close_min_in  = csr_data;
            alm_pkg::CSR_CLOSE_PRESENT:   close_pres_in = csr_data[0];
            default: ;
         endcase
         if (csr_index <= alm_pkg::CSR_CLOSE_PRESENT) begin
            open_valid_in  = 1'b0;
            close_valid_in = 1'b0;
            completed_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         repeat_ff      <= 1'b0;
         open_min_ff    <= '0;
         open_pres_ff   <= 1'b0;
         close_min_ff   <= '0;
         close_pres_ff  <= 1'b0;
         open_valid_ff  <= 1'b0;
         close_valid_ff <= 1'b0;
         completed_ff   <= 1'b0;
      end else begin
         enable_ff      <= enable_in;
         repeat_ff      <= repeat_in;
         open_min_ff    <= open_min_in;
         open_pres_ff   <= open_pres_in;
         close_min_ff   <= close_min_in;
         close_pres_ff  <= close_pres_in;
         open_valid_ff  <= open_valid_in;
         close_valid_ff <= close_valid_in;
         completed_ff   <= completed_in;
      end
      open_day_ff  <= open_day_in;
      close_day_ff <= close_day_in;
   end

endmodule

// ===== src/alm_ctrl.sv =====
`include "alarm_list_and_daily_timer_macros.svh"

module alm_ctrl #(
   parameter int ALARM_SLOTS = alm_pkg::ALARM_SLOTS_DEFAULT,
   localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1,
   localparam int CW = $clog2(ALARM_SLOTS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   alm_req_if.sink                  req,
   alm_rsp_if.source                rsp,
   input  alm_pkg::daily_type       daily,
   output alm_pkg::daily_ctrl_type  daily_ctrl,
   output logic                     mem_rd_en,
   output logic [AW-1:0]            mem_rd_addr,
   input  alm_pkg::entry_type       mem_rd_data,
   output logic                     mem_wr_en,
   output logic [AW-1:0]            mem_wr_addr,
   output alm_pkg::entry_type       mem_wr_data
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_WALK    = 5'b00010,
      ST_COMPACT = 5'b00100,
      ST_DAILY   = 5'b01000,
      ST_FLUSH   = 5'b10000
   } state_type;

   localparam logic [CW-1:0] SLOTS_C = CW'(ALARM_SLOTS);

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [AW-1:0]                    ptr_ff, ptr_in;
   logic [CW-1:0]                    rp_ff, rp_in;
   logic [CW-1:0]                    wp_ff, wp_in;
   logic                             dv_ff, dv_in;
   logic [AW-1:0]                    di_ff, di_in;
   logic [ALARM_SLOTS-1:0]           mask_ff, mask_in;
   logic [alm_pkg::FIRE_CNT_W-1:0]   fcnt_ff, fcnt_in;
   logic                             tick_ff, tick_in;
   logic [alm_pkg::MINUTE_W-1:0]     now_ff, now_in;
   logic                             open_pend_ff, open_pend_in;
   logic                             close_pend_ff, close_pend_in;
   logic                             da_ff, da_in;
   logic                             pend_valid_ff, pend_valid_in;
   alm_pkg::result_type              pend_ff, pend_in;
   logic                             out_valid_ff, out_valid_in;
   alm_pkg::result_type              out_ff, out_in;
   logic                             out_last_ff, out_last_in;
   logic                             out_da_ff, out_da_in;

   logic                 out_free, gen_ok, gen, flush, hit, last_fire;
   alm_pkg::result_type  gen_res, none_res;

   assign req.ready = (state_ff == ST_IDLE);
   assign out_free  = !out_valid_ff || rsp.ready;
   assign gen_ok    = !pend_valid_ff || out_free;
   assign hit       = (mem_rd_data.minute == now_ff);
   assign last_fire = hit && (fcnt_ff == alm_pkg::FIRE_CNT_LAST);

   assign daily_ctrl.eval   = (req.action == alm_pkg::ACTION_TICK) && req.clock_synced;
   assign daily_ctrl.commit = req.valid && req.ready && daily_ctrl.eval;

   always_comb begin
      none_res = '{kind: alm_pkg::KIND_NONE, slot: '0, fired_action: '0, fired_reply: '0};

      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      dv_in         = dv_ff;
      di_in         = di_ff;
      mask_in       = mask_ff;
      fcnt_in       = fcnt_ff;
      tick_in       = tick_ff;
      now_in        = now_ff;
      open_pend_in  = open_pend_ff;
      close_pend_in = close_pend_ff;
      da_in         = da_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_da_in     = out_da_ff;

      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = AW'(wp_ff);
      mem_wr_data = mem_rd_data;
      gen         = 1'b0;
      gen_res     = none_res;
      flush       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               da_in         = daily.active;
               now_in        = req.now_minute;
               open_pend_in  = daily.fire_open;
               close_pend_in = daily.fire_close;
               tick_in       = (req.action == alm_pkg::ACTION_TICK);
               mask_in       = '0;
               fcnt_in       = '0;
               rp_in         = '0;
               wp_in         = '0;
               dv_in         = 1'b0;
               unique case (req.action)
                  alm_pkg::ACTION_TICK: begin
                     if (!req.clock_synced) begin
                        state_in = ST_FLUSH;
                     end else if (count_ff != '0) begin
                        // walk from the top slot down
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(count_ff - CW'(1));
                        ptr_in      = AW'(count_ff - CW'(1));
                        state_in    = ST_WALK;
                     end else begin
                        state_in = ST_DAILY;
                     end
                  end
                  alm_pkg::ACTION_ADD: begin
                     pend_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                     if (count_ff < SLOTS_C) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(count_ff);
                        mem_wr_data = '{minute: req.alarm_minute, action: req.alarm_action,
                                        reply: req.alarm_reply};
                        count_in    = count_ff + CW'(1);
                        pend_in     = '{kind: alm_pkg::KIND_ADDED,
                                        slot: alm_pkg::SLOT_W'(count_ff),
                                        fired_action: '0, fired_reply: '0};
                     end else begin
                        pend_in = '{kind: alm_pkg::KIND_FULL, slot: '0,
                                    fired_action: '0, fired_reply: '0};
                     end
                  end
                  alm_pkg::ACTION_REMOVE: begin
                     pend_valid_in = 1'b1;
                     if (32'(req.slot_index) < 32'(count_ff)) begin
                        mask_in  = ALARM_SLOTS'(1) << AW'(req.slot_index);
                        pend_in  = '{kind: alm_pkg::KIND_REMOVED,
                                     slot: alm_pkg::SLOT_W'(req.slot_index),
                                     fired_action: '0, fired_reply: '0};
                        state_in = ST_COMPACT;
                     end else begin
                        pend_in  = '{kind: alm_pkg::KIND_IGNORED, slot: '0,
                                     fired_action: '0, fired_reply: '0};
                        state_in = ST_FLUSH;
                     end
                  end
                  default: begin
                     pend_valid_in = 1'b1;
                     pend_in       = '{kind: alm_pkg::KIND_IGNORED, slot: '0,
                                       fired_action: '0, fired_reply: '0};
                     state_in      = ST_FLUSH;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // hold the read data while a fired result cannot be staged
            if (!hit || gen_ok) begin
               if (hit) begin
                  gen              = 1'b1;
                  gen_res          = '{kind: alm_pkg::KIND_ONE_SHOT,
                                       slot: alm_pkg::SLOT_W'(ptr_ff),
                                       fired_action: mem_rd_data.action,
                                       fired_reply: mem_rd_data.reply};
                  mask_in[ptr_ff]  = 1'b1;
                  fcnt_in          = fcnt_ff + alm_pkg::FIRE_CNT_W'(1);
               end
               if (ptr_ff == '0 || last_fire) begin
                  state_in = (hit || fcnt_ff != '0) ? ST_COMPACT : ST_DAILY;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_ff - AW'(1);
                  ptr_in      = ptr_ff - AW'(1);
               end
            end
         end

         ST_COMPACT: begin
            // read ahead and write kept entries down to the write pointer
            if (rp_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(rp_ff);
               rp_in       = rp_ff + CW'(1);
               dv_in       = 1'b1;
               di_in       = AW'(rp_ff);
            end else begin
               dv_in = 1'b0;
            end
            if (dv_ff && !mask_ff[di_ff]) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = AW'(wp_ff);
               mem_wr_data = mem_rd_data;
               wp_in       = wp_ff + CW'(1);
            end
            if (!dv_ff && rp_ff == count_ff) begin
               count_in = wp_ff;
               state_in = tick_ff ? ST_DAILY : ST_FLUSH;
            end
         end

         ST_DAILY: begin
            if (open_pend_ff) begin
               if (gen_ok) begin
                  gen          = 1'b1;
                  gen_res      = '{kind: alm_pkg::KIND_OPEN, slot: '0,
                                   fired_action: '0, fired_reply: '0};
                  open_pend_in = 1'b0;
               end
            end else if (close_pend_ff) begin
               if (gen_ok) begin
                  gen           = 1'b1;
                  gen_res       = '{kind: alm_pkg::KIND_CLOSE, slot: '0,
                                    fired_action: '0, fired_reply: '0};
                  close_pend_in = 1'b0;
               end
            end else begin
               state_in = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               flush    = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // output register: one staged result trails the newest so the final one
      // can carry last
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (flush) begin
         out_valid_in  = 1'b1;
         out_in        = pend_valid_ff ? pend_ff : none_res;
         out_last_in   = 1'b1;
         out_da_in     = da_ff;
         pend_valid_in = 1'b0;
      end else if (gen) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_last_in  = 1'b0;
            out_da_in    = da_ff;
         end
         pend_in       = gen_res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rp_ff         <= '0;
         wp_ff         <= '0;
         dv_ff         <= 1'b0;
         fcnt_ff       <= '0;
         open_pend_ff  <= 1'b0;
         close_pend_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         dv_ff         <= dv_in;
         fcnt_ff       <= fcnt_in;
         open_pend_ff  <= open_pend_in;
         close_pend_ff <= close_pend_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      ptr_ff      <= ptr_in;
      di_ff       <= di_in;
      mask_ff     <= mask_in;
      tick_ff     <= tick_in;
      now_ff      <= now_in;
      da_ff       <= da_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_da_ff   <= out_da_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_ff.kind;
   assign rsp.slot         = out_ff.slot;
   assign rsp.fired_action = out_ff.fired_action;
   assign rsp.fired_reply  = out_ff.fired_reply;
   assign rsp.daily_active = out_da_ff;
   assign rsp.last         = out_last_ff;

   `ALM_ASSERT(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff, "staged result left over in idle")
   `ALM_ASSERT(a_count_bound, clock, reset, 1'b1, count_ff <= SLOTS_C, "alarm count above slot count")
   `ALM_ASSERT(a_walk_ptr, clock, reset, state_ff == ST_WALK, 32'(ptr_ff) < 32'(count_ff), "walk pointer past list end")
   `ALM_ASSERT(a_compact_order, clock, reset, mem_wr_en && state_ff == ST_COMPACT, wp_ff < rp_ff, "compaction write overtook read")
   `ALM_ASSERT_NEXT(a_flush_last, clock, reset, state_ff == ST_FLUSH && out_free, out_valid_ff && out_last_ff, "final result not marked last")

endmodule

// ===== src/alarm_list_and_daily_timer.sv =====
// Alarm unit: a compacted list of one-shot alarms plus one daily open/close alarm.
// Requests arrive on req_bus (tick, add, remove); every request yields one or more
// transfers on rsp_bus, the final one flagged by last. The user must write registers
// on the csr_ port only while the unit is idle; the unit itself does not enforce it.
// A write to a listed csr_ register clears the daily day marks. With n = alarms in
// the list and f = one-shots that fire: add, remove of a missing slot and unsynced
// tick go straight to the result; remove runs a compaction pass; a synced tick walks
// the n alarms from the top down, stopping early at the eighth fire, then runs a
// compaction pass when f > 0 and gives the daily results and a final transfer.
// The slot store has a single read port: the walk reads one slot per cycle while
// each fired result can be staged, and compaction reads one entry per cycle and writes each kept one down.
// A new request is taken once the previous one has handed its last result to the
// output register, even while that register still waits for the receiver.
// When the receiver stalls, at most one result sits in the output register and one
// in the staging register; the walk holds until they drain.
// Synchronous reset empties the list, clears the registers and day marks; store
// contents are not cleared, since slots above the count are never read.
module alarm_list_and_daily_timer #(
   parameter int ALARM_SLOTS = alm_pkg::ALARM_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   alm_req_if.sink                           req_bus,
   alm_rsp_if.source                         rsp_bus,
   input  logic                              csr_write_en,
   input  logic [alm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [alm_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

   alm_pkg::daily_type       daily;
   alm_pkg::daily_ctrl_type  daily_ctrl;
   logic                     mem_rd_en, mem_wr_en;
   logic [AW-1:0]            mem_rd_addr, mem_wr_addr;
   alm_pkg::entry_type       mem_rd_data, mem_wr_data;

   alm_daily u_daily (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .ctrl         (daily_ctrl),
      .now_minute   (req_bus.now_minute),
      .day_of_year  (req_bus.day_of_year),
      .status       (daily)
   );

   alm_store #(.ALARM_SLOTS(ALARM_SLOTS)) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   alm_ctrl #(.ALARM_SLOTS(ALARM_SLOTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .daily       (daily),
      .daily_ctrl  (daily_ctrl),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

endmodule
